@@ design/ucf_pkg.sv @@
`default_nettype none
package ucf_pkg;
	typedef struct packed {
		logic       cmd;
		logic [5:0] node_a;
		logic [5:0] node_b;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [5:0] vertex;
		logic       last;
	} res_t;

	localparam logic [1:0] ST_CYCLE = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_LOST  = 2'd2;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_CLEAR,
		OP_CHECK_RD,
		OP_CHECK,
		OP_SEED,
		OP_POP_RD,
		OP_POP,
		OP_SCAN_RD,
		OP_SCAN,
		OP_UP,
		OP_DN,
		OP_TRIM,
		OP_EMIT_UP,
		OP_EMIT_DN
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic edges_done;
		logic bad_edge;
		logic visited_s;
		logic nodes_done;
		logic queue_empty;
		logic found;
		logic walk_done;
		logic trim_done;
		logic emit_done;
		logic [5:0] cu;
	} sts_t;
endpackage
`default_nettype wire

@@ design/ucf_ctrl.sv @@
`default_nettype none
module ucf_ctrl import ucf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire logic lost,
	input  sts_t      sts,
	output cmd_t      cmd,
	output logic      busy,
	output logic      done_fire,
	output res_t      done_res
);
	typedef enum logic [3:0] {
		S_IDLE, S_CHKRD, S_CHK, S_SEED, S_POPRD, S_POP, S_SCANRD, S_SCAN,
		S_UP, S_DN, S_TRIM, S_EUP, S_EDN, S_CLEAR
	} state_t;
	state_t state_q;

	always_comb begin
		cmd.op = OP_NOP;
		unique case (state_q)
			S_CHKRD:  cmd.op = OP_CHECK_RD;
			S_CHK:    cmd.op = OP_CHECK;
			S_SEED:   cmd.op = OP_SEED;
			S_POPRD:  cmd.op = OP_POP_RD;
			S_POP:    cmd.op = OP_POP;
			S_SCANRD: cmd.op = OP_SCAN_RD;
			S_SCAN:   cmd.op = OP_SCAN;
			S_UP:     cmd.op = OP_UP;
			S_DN:     cmd.op = OP_DN;
			S_TRIM:   cmd.op = OP_TRIM;
			S_EUP:    cmd.op = OP_EMIT_UP;
			S_EDN:    cmd.op = OP_EMIT_DN;
			S_CLEAR:  cmd.op = OP_CLEAR;
			default:  cmd.op = OP_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			done_fire <= 1'b0;
			done_res  <= '0;
		end else begin
			done_fire <= 1'b0;
			unique case (state_q)
				S_IDLE: if (go) begin
					if (lost) begin
						done_fire <= 1'b1;
						done_res  <= '{ST_LOST, 6'd0, 1'b1};
						state_q   <= S_CLEAR;
					end else state_q <= S_CHKRD;
				end
				S_CHKRD: state_q <= sts.edges_done ? S_SEED : S_CHK;
				S_CHK: begin
					if (sts.bad_edge) begin
						done_fire <= 1'b1;
						done_res  <= '{ST_LOST, 6'd0, 1'b1};
						state_q   <= S_CLEAR;
					end else state_q <= S_CHKRD;
				end
				S_SEED: begin
					if (sts.nodes_done) begin
						done_fire <= 1'b1;
						done_res  <= '{ST_NONE, 6'd0, 1'b1};
						state_q   <= S_CLEAR;
					end else if (!sts.visited_s) state_q <= S_POPRD;
				end
				S_POPRD: state_q <= S_POP;
				S_POP: state_q <= sts.queue_empty ? S_SEED : S_SCANRD;
				S_SCANRD: state_q <= sts.edges_done ? S_POPRD : S_SCAN;
				S_SCAN: state_q <= sts.found ? S_UP : S_SCANRD;
				S_UP: if (sts.walk_done) state_q <= S_DN;
				S_DN: if (sts.walk_done) state_q <= S_TRIM;
				S_TRIM: if (sts.trim_done) state_q <= S_EUP;
				S_EUP: if (sts.emit_done) state_q <= S_EDN;
				S_EDN: if (sts.emit_done) begin
					done_fire <= 1'b1;
					done_res  <= '{ST_CYCLE, sts.cu, 1'b1};
					state_q   <= S_CLEAR;
				end
				S_CLEAR: if (sts.walk_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/ucf_dp.sv @@
`default_nettype none
module ucf_dp import ucf_pkg::*; #(
	parameter int MAX_NODES = 63,
	parameter int MAX_EDGES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic add_fire,
	input  req_t      req,
	input  wire logic [5:0] node_count,
	input  cmd_t      cmd,
	output sts_t      sts,
	output logic      lost,
	output logic      emit_fire,
	output res_t      emit_res
);
	localparam int EW = $clog2(MAX_EDGES + 1);
	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

	logic [11:0] edge_mem [MAX_EDGES];
	logic [11:0] erd_q;
	logic [EW-1:0] etot_q, eidx_q;
	logic lost_q;
	logic [63:0] vis_q;
	logic [5:0] par [64];
	logic [11:0] que [64];
	logic [5:0] pup [64];
	logic [5:0] pdn [64];
	logic [11:0] que_rd_q;
	logic [5:0] par_rd_q;
	logic [6:0] head_q, tail_q;
	logic [5:0] s_q, u_q, pu_q, cu_q, cv_q, x_q;
	logic [6:0] l1_q, l2_q, k_q, cnt_q;
	logic signed [7:0] i_q, j_q;
	logic [5:0] pi_q, pj_q, pk_q;
	logic phase_q;
	logic [5:0] n_eff;

	assign n_eff = (node_count > 6'(MAX_NODES)) ? 6'(MAX_NODES) : node_count;
	assign lost = lost_q;

	wire [5:0] ea = erd_q[11:6];
	wire [5:0] eb = erd_q[5:0];
	wire       hit = phase_q ? (eb == u_q) : (ea == u_q);
	wire [5:0] vv  = phase_q ? ea : eb;
	wire       skip = (vv == pu_q);

	wire add_bad = (req.node_a == 6'd0) || (req.node_a > n_eff) || (req.node_b == 6'd0) ||
		(req.node_b > n_eff) || (etot_q >= EW'(MAX_EDGES));
	wire add_ok = add_fire && !add_bad;

	always_comb begin
		sts = '0;
		sts.edges_done = (eidx_q >= etot_q);
		sts.bad_edge = (ea == 6'd0) || (ea > n_eff) || (eb == 6'd0) || (eb > n_eff);
		sts.visited_s = vis_q[s_q];
		sts.nodes_done = (s_q > n_eff) || (s_q == 6'd0);
		sts.queue_empty = (head_q >= tail_q);
		sts.found = hit && !skip && vis_q[vv];
		sts.walk_done = (cmd.op == OP_CLEAR) ? (k_q == 7'd63) : (x_q == 6'd0);
		sts.trim_done = (k_q != 7'd127) && (k_q != 7'd126) &&
			!(i_q >= 0 && j_q >= 0 && pi_q == pj_q);
		sts.emit_done = (cmd.op == OP_EMIT_UP) ?
			(8'(signed'({1'b0, k_q})) > i_q + 8'sd1 || k_q >= l1_q || cnt_q >= 7'd63)
			: (j_q < 0 || cnt_q >= 7'd63);
		sts.cu = cu_q;
	end

	wire seed_new  = (cmd.op == OP_SEED) && !sts.nodes_done && !vis_q[s_q];
	wire visit_new = (cmd.op == OP_SCAN) && hit && !skip && !vis_q[vv];
	wire up_wr = (cmd.op == OP_UP) && (x_q != 6'd0) && (l1_q < 7'd64) && phase_q;
	wire dn_wr = (cmd.op == OP_DN) && (x_q != 6'd0) && (l2_q < 7'd64) && phase_q;

	always_ff @(posedge clk) begin
		if (add_ok) edge_mem[etot_q[AW-1:0]] <= {req.node_a, req.node_b};
		if (seed_new) begin
			par[s_q] <= '0;
			que[0] <= {s_q, 6'd0};
		end
		if (visit_new) begin
			par[vv] <= u_q;
			if (tail_q < 7'd64) que[tail_q[5:0]] <= {vv, u_q};
		end
		if (up_wr) pup[l1_q[5:0]] <= x_q;
		if (dn_wr) pdn[l2_q[5:0]] <= x_q;
		erd_q <= edge_mem[eidx_q[AW-1:0]];
		que_rd_q <= que[head_q[5:0]];
		par_rd_q <= par[x_q];
		pi_q <= pup[i_q[5:0]];
		pj_q <= pdn[j_q[5:0]];
		pk_q <= pup[k_q[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			etot_q <= '0; eidx_q <= '0; lost_q <= 1'b0; vis_q <= '0;
			head_q <= '0; tail_q <= '0; s_q <= 6'd1; u_q <= '0; pu_q <= '0;
			cu_q <= '0; cv_q <= '0; x_q <= '0; l1_q <= '0; l2_q <= '0;
			k_q <= '0; cnt_q <= '0; i_q <= '0; j_q <= '0; phase_q <= 1'b0;
			emit_fire <= 1'b0; emit_res <= '0;
		end else begin
			emit_fire <= 1'b0;
			if (add_fire) begin
				if (add_bad) lost_q <= 1'b1;
				else etot_q <= etot_q + 1'b1;
			end
			case (cmd.op)
				OP_CHECK: eidx_q <= eidx_q + 1'b1;
				OP_SEED: begin
					eidx_q <= '0;
					if (!sts.nodes_done) begin
						if (!vis_q[s_q]) begin
							vis_q[s_q] <= 1'b1;
							head_q <= '0;
							tail_q <= 7'd1;
						end
						s_q <= s_q + 1'b1;
					end
				end
				OP_POP: if (!sts.queue_empty) begin
					u_q <= que_rd_q[11:6];
					pu_q <= que_rd_q[5:0];
					head_q <= head_q + 1'b1;
					eidx_q <= '0;
					phase_q <= 1'b0;
				end
				OP_SCAN: begin
					if (hit && !skip) begin
						if (!vis_q[vv]) begin
							vis_q[vv] <= 1'b1;
							if (tail_q < 7'd64) tail_q <= tail_q + 1'b1;
						end else begin
							cu_q <= u_q; cv_q <= vv; x_q <= u_q; l1_q <= '0;
							phase_q <= 1'b0;
						end
					end
					if (!sts.found) begin
						if (phase_q) begin
							phase_q <= 1'b0;
							eidx_q <= eidx_q + 1'b1;
						end else phase_q <= 1'b1;
					end
				end
				OP_UP: if (x_q != 0 && l1_q < 7'd64) begin
					if (phase_q) begin
						l1_q <= l1_q + 1'b1;
						x_q <= par_rd_q;
						phase_q <= 1'b0;
					end else phase_q <= 1'b1;
				end else begin
					x_q <= cv_q; l2_q <= '0; phase_q <= 1'b0;
				end
				OP_DN: if (x_q != 0 && l2_q < 7'd64) begin
					if (phase_q) begin
						l2_q <= l2_q + 1'b1;
						x_q <= par_rd_q;
						phase_q <= 1'b0;
					end else phase_q <= 1'b1;
				end else begin
					i_q <= 8'(l1_q) - 8'sd1;
					j_q <= 8'(l2_q) - 8'sd1;
					k_q <= 7'd127;
					phase_q <= 1'b0;
				end
				OP_TRIM: begin
					if (k_q == 7'd127 || k_q == 7'd126) k_q <= '0;
					else if (!sts.trim_done) begin
						i_q <= i_q - 8'sd1; j_q <= j_q - 8'sd1; k_q <= 7'd126;
					end else begin
						k_q <= '0; cnt_q <= '0; phase_q <= 1'b0;
					end
				end
				OP_EMIT_UP: if (!sts.emit_done) begin
					if (phase_q) begin
						emit_fire <= 1'b1;
						emit_res <= '{ST_CYCLE, pk_q, 1'b0};
						k_q <= k_q + 1'b1; cnt_q <= cnt_q + 1'b1;
						phase_q <= 1'b0;
					end else phase_q <= 1'b1;
				end
				OP_EMIT_DN: if (!sts.emit_done) begin
					if (phase_q) begin
						emit_fire <= 1'b1;
						emit_res <= '{ST_CYCLE, pj_q, 1'b0};
						j_q <= j_q - 8'sd1; cnt_q <= cnt_q + 1'b1;
						phase_q <= 1'b0;
					end else phase_q <= 1'b1;
				end else k_q <= '0;
				OP_CLEAR: begin
					if (k_q == 7'd63) begin
						etot_q <= '0; lost_q <= 1'b0; vis_q <= '0; s_q <= 6'd1;
						eidx_q <= '0; x_q <= '0;
					end
					k_q <= (k_q == 7'd63) ? 7'd0 : k_q + 1'b1;
				end
				OP_CHECK_RD, OP_POP_RD, OP_SCAN_RD, OP_NOP: ;
				default: ;
			endcase
			if (cmd.op == OP_NOP) k_q <= '0;
		end
	end
endmodule
`default_nettype wire

@@ design/undirected_cycle_finder.sv @@
`default_nettype none
// Add-edge request: accepted while busy is low, and busy stays low. Run request: busy from the next
// cycle; it checks each stored edge, visits each seed node, scans every stored edge for each
// dequeued node, walks the path vertices, emits the cycle vertices, then clears its state.
// Results appear on done; the receiver cannot stall, and no new request is accepted while busy.
// Asynchronous active-low reset empties the edge list; node_count resets to 63.
module undirected_cycle_finder import ucf_pkg::*; #(
	parameter int MAX_NODES = 63,
	parameter int MAX_EDGES = 256
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  req_t      req,
	output logic      done,
	output res_t      res,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic      pready
);
	logic [5:0] node_count_q;
	cmd_t c; sts_t s;
	logic lost, ef, df;
	res_t er, dr;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {26'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= 6'd63;
		else if (psel && penable && pwrite && paddr == 2'd0) node_count_q <= pwdata[5:0];
	end

	wire acc = start && !busy;

	ucf_ctrl u_ctrl (.clk, .arst_n, .go(acc && req.cmd), .lost, .sts(s), .cmd(c),
		.busy, .done_fire(df), .done_res(dr));

	ucf_dp #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (.clk, .arst_n,
		.add_fire(acc && !req.cmd), .req, .node_count(node_count_q), .cmd(c),
		.sts(s), .lost, .emit_fire(ef), .emit_res(er));

	assign done = ef | df;
	assign res  = df ? dr : er;
endmodule
`default_nettype wire
